>>> sv/bdp_pkg.sv
// shared types, constants and codes for the beacon datagram parser
`timescale 1ns / 1ps
package bdp_pkg;

   localparam int unsigned CNT_W        = 16;
   localparam int unsigned END_W        = 20;
   localparam int unsigned MAX_BYTES_DEF = 1024;
   localparam int unsigned HDR_BYTES    = 16;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NAME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MOTD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_SIZE = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [2:0] ST_BAD_PROTO = 3'd3;
   localparam logic [2:0] ST_NAME_LONG = 3'd4;
   localparam logic [2:0] ST_NAME_TRUNC = 3'd5;

   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] proto;
      logic [15:0] max_name;
      logic [15:0] max_motd;
      logic [2:0]  char_bytes;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] byte_count;
      logic [31:0]      magic;
      logic [15:0]      proto;
      logic [15:0]      netver;
      logic [15:0]      port;
      logic [7:0]       players;
      logic [7:0]       max_players;
      logic [7:0]       mode;
      logic             private_bit;
      logic [15:0]      name_len;
      logic [END_W-1:0] name_end;
      logic [15:0]      motd_len;
      logic [END_W-1:0] motd_end;
   } frame_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] proto_version;
      logic [15:0] net_version;
      logic [15:0] tcp_port;
      logic [7:0]  player_count;
      logic [7:0]  max_players;
      logic [7:0]  game_mode;
      logic        private_game;
      logic [15:0] name_chars;
      logic        motd_present;
      logic [15:0] motd_chars;
   } result_type;

endpackage

>>> sv/bdp_csr.sv
// configuration registers of the beacon datagram parser
`timescale 1ns / 1ps
module bdp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bdp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdp_pkg::CSR_DAT_W-1:0]    csr_wdata,
   output bdp_pkg::cfg_type                 cfg
);
   import bdp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAGIC:     cfg_in.magic      = csr_wdata;
            CSR_PROTO:     cfg_in.proto      = csr_wdata[15:0];
            CSR_MAX_NAME:  cfg_in.max_name   = csr_wdata[15:0];
            CSR_MAX_MOTD:  cfg_in.max_motd   = csr_wdata[15:0];
            CSR_CHAR_SIZE: cfg_in.char_bytes = csr_wdata[2:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic      <= 32'd0;
         cfg_ff.proto      <= 16'd2;
         cfg_ff.max_name   <= 16'd64;
         cfg_ff.max_motd   <= 16'd64;
         cfg_ff.char_bytes <= 3'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/bdp_collect.sv
// header field collector: frame state and per-byte field update
`timescale 1ns / 1ps
module bdp_collect #(
   parameter int unsigned MAX_BYTES = bdp_pkg::MAX_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   input  logic [2:0]         char_bytes,
   output bdp_pkg::frame_type frame_upd
);
   import bdp_pkg::*;

   localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_BYTES);
   localparam logic [END_W-1:0] HdrEnd = END_W'(HDR_BYTES);

   frame_type        frame_ff;
   frame_type        frame_in;
   logic [CNT_W-1:0] pos;
   logic [18:0]      name_prod;
   logic [18:0]      motd_prod;
   logic [15:0]      name_full;
   logic [15:0]      motd_full;

   assign pos       = frame_ff.byte_count;
   assign name_full = {data_byte, frame_ff.name_len[7:0]};
   assign motd_full = {data_byte, frame_ff.motd_len[7:0]};
   assign name_prod = {3'd0, name_full} * {16'd0, char_bytes};
   assign motd_prod = {3'd0, motd_full} * {16'd0, char_bytes};

   always_comb begin
      frame_upd = frame_ff;
      if (pos < MaxCnt) begin
         frame_upd.byte_count = pos + 16'd1;
         if (pos < 16'd4) begin
            frame_upd.magic = {data_byte, frame_ff.magic[31:8]};
         end else if (pos == 16'd4) begin
            frame_upd.proto = {8'd0, data_byte};
         end else if (pos == 16'd5) begin
            frame_upd.proto[15:8] = data_byte;
         end else if (pos == 16'd6) begin
            frame_upd.netver = {8'd0, data_byte};
         end else if (pos == 16'd7) begin
            frame_upd.netver[15:8] = data_byte;
         end else if (pos == 16'd8) begin
            frame_upd.port = {8'd0, data_byte};
         end else if (pos == 16'd9) begin
            frame_upd.port[15:8] = data_byte;
         end else if (pos == 16'd10) begin
            frame_upd.players = data_byte;
         end else if (pos == 16'd11) begin
            frame_upd.max_players = data_byte;
         end else if (pos == 16'd12) begin
            frame_upd.mode = data_byte;
         end else if (pos == 16'd13) begin
            frame_upd.private_bit = data_byte[0];
         end else if (pos == 16'd14) begin
            frame_upd.name_len = {8'd0, data_byte};
         end else if (pos == 16'd15) begin
            frame_upd.name_len = name_full;
            frame_upd.name_end = HdrEnd + {1'b0, name_prod};
         end else if ({4'd0, pos} == frame_ff.name_end) begin
            frame_upd.motd_len = {8'd0, data_byte};
         end else if ({5'd0, pos} == ({1'b0, frame_ff.name_end} + 21'd1)) begin
            // message length complete: offset just past the message text
            frame_upd.motd_len = motd_full;
            frame_upd.motd_end = frame_ff.name_end + 20'd2 + {1'b0, motd_prod};
         end
      end
   end

   always_comb begin
      frame_in = frame_ff;
      if (take) begin
         frame_in = last_byte ? '0 : frame_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

endmodule

>>> sv/bdp_check.sv
// header checks and result assembly for a finished datagram
`timescale 1ns / 1ps
module bdp_check (
   input  bdp_pkg::frame_type  frame,
   input  bdp_pkg::cfg_type    cfg,
   output bdp_pkg::result_type result
);
   import bdp_pkg::*;

   logic [CNT_W-1:0] len;
   logic             motd_ok;

   assign len = frame.byte_count;

   assign motd_ok = (frame.proto >= 16'd2)
                  && (({1'b0, frame.name_end} + 21'd2) <= {5'd0, len})
                  && (frame.motd_len <= cfg.max_motd)
                  && (frame.motd_end <= {4'd0, len});

   always_comb begin
      result.proto_version = frame.proto;
      result.net_version   = frame.netver;
      result.tcp_port      = frame.port;
      result.player_count  = frame.players;
      result.max_players   = frame.max_players;
      result.game_mode     = frame.mode;
      result.private_game  = frame.private_bit;
      result.name_chars    = frame.name_len;
      result.motd_present  = 1'b0;
      result.motd_chars    = 16'd0;
      if (len < CNT_W'(HDR_BYTES)) begin
         result.status = ST_SHORT;
      end else if (frame.magic != cfg.magic) begin
         result.status = ST_BAD_MAGIC;
      end else if (frame.proto != 16'd1 && frame.proto != cfg.proto) begin
         result.status = ST_BAD_PROTO;
      end else if (frame.name_len > cfg.max_name) begin
         result.status = ST_NAME_LONG;
      end else if (frame.name_end > {4'd0, len}) begin
         result.status = ST_NAME_TRUNC;
      end else begin
         result.status = ST_OK;
         // a bad or cut-short message is simply reported as absent
         if (motd_ok) begin
            result.motd_present = 1'b1;
            result.motd_chars   = frame.motd_len;
         end
      end
   end

endmodule

>>> sv/beacon_datagram_parse_top.sv
// top level of the beacon datagram parser: handshake, result register
// latency: the result appears in rsp_* the cycle after the last byte is accepted
// throughput: one byte item per cycle while req_ready is high; field update and checks run in one pass
// a result waiting in the output register does not stall bytes while rsp_ready is high
// reset (synchronous, active high) clears the frame state and empties the output
// reset also returns the configuration registers to their default values
`timescale 1ns / 1ps
module beacon_datagram_parse_top #(
   parameter int unsigned MAX_BYTES = bdp_pkg::MAX_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [15:0]                   rsp_proto_version,
   output logic [15:0]                   rsp_net_version,
   output logic [15:0]                   rsp_tcp_port,
   output logic [7:0]                    rsp_player_count,
   output logic [7:0]                    rsp_max_players,
   output logic [7:0]                    rsp_game_mode,
   output logic                          rsp_private_game,
   output logic [15:0]                   rsp_name_chars,
   output logic                          rsp_motd_present,
   output logic [15:0]                   rsp_motd_chars,
   input  logic                          csr_write_en,
   input  logic [bdp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdp_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import bdp_pkg::*;

   cfg_type    cfg;
   frame_type  frame_upd;
   result_type result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   bdp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bdp_collect #(
      .MAX_BYTES (MAX_BYTES)
   ) u_collect (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .char_bytes (cfg.char_bytes),
      .frame_upd  (frame_upd)
   );

   bdp_check u_check (
      .frame  (frame_upd),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && req_last_byte) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_proto_version = rsp_ff.proto_version;
   assign rsp_net_version   = rsp_ff.net_version;
   assign rsp_tcp_port      = rsp_ff.tcp_port;
   assign rsp_player_count  = rsp_ff.player_count;
   assign rsp_max_players   = rsp_ff.max_players;
   assign rsp_game_mode     = rsp_ff.game_mode;
   assign rsp_private_game  = rsp_ff.private_game;
   assign rsp_name_chars    = rsp_ff.name_chars;
   assign rsp_motd_present  = rsp_ff.motd_present;
   assign rsp_motd_chars    = rsp_ff.motd_chars;

   // a last byte always leaves a result behind
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (take && req_last_byte) |=> rsp_valid_ff)
      else $error("last byte accepted but no result pending");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status <= ST_NAME_TRUNC))
      else $error("result status out of range");

   a_motd_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.motd_present) |-> (rsp_ff.status == ST_OK))
      else $error("message reported on a failed datagram");

   a_motd_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.motd_present) |-> (rsp_ff.motd_chars == 16'd0))
      else $error("message length nonzero while absent");

endmodule
